// ----- sv/rgbpfc_pkg.sv -----
package rgbpfc_pkg;

    // pixel geometry
    localparam int PIX_BYTES = 4;
    localparam int BYTE_W    = 8;
    localparam int PIX_W     = PIX_BYTES * BYTE_W;
    localparam int POS_W     = $clog2(PIX_BYTES);
    localparam int CNT_W     = $clog2(PIX_BYTES + 1);
    localparam int COMP_N    = 3;

    // format word layout
    localparam int FMT_W     = 29;
    localparam int LOSS_W    = 4;
    localparam int SHIFT_W   = 5;
    localparam int LOSS_LSB  = 2;
    localparam int SHIFT_LSB = 14;
    localparam int NO_BITS   = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_FMT = 2'd0,
        REG_TGT_FMT = 2'd1,
        REG_SRC_BE  = 2'd2,
        REG_TGT_BE  = 2'd3
    } cfg_reg_t;

    // decoded format, per component r, g, b
    typedef struct packed {
        logic                               bad;
        logic [COMP_N-1:0][LOSS_W-1:0]      loss;
        logic [COMP_N-1:0][SHIFT_W-1:0]     shift;
        logic [COMP_N-1:0][POS_W-1:0]       pos;
    } fmt_t;

endpackage

// ----- sv/rgb_pixel_format_convert.sv -----
// channel   | port group              | contents
// ----------+-------------------------+--------------------------------------------
// input     | s_tvalid/s_tready       | s_tdata: source_pixel, s_tlast: last_in
// output    | m_tvalid/m_tready       | m_tdata: target_pixel, m_tlast: last_out,
//           |                         | m_tuser: format_error
// config    | cfg_we/cfg_index        | cfg_wdata: register value, no read-back
//
// three register stages: source byte extract, field move and mask, byte placement into the
// output register; one color per cycle unless m_tready stalls; format decode is
// combinational from the config registers; the user must change them only while idle,
// not enforced by the block; synchronous active-low reset clears the config registers
// and all stage valid bits; a stall on m_tready backs up through the stages; each stage
// loads when it is empty or the stage after it loads, so nothing is lost or repeated
module rgb_pixel_format_convert
    import rgbpfc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FMT_W-1:0]     cfg_wdata,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,   // [31:0] source_pixel
    input  logic                 s_tlast,
    // output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIX_W-1:0]     m_tdata,   // [31:0] target_pixel
    output logic                 m_tlast,
    output logic                 m_tuser    // [0] format_error
);

    logic [FMT_W-1:0] src_fmt_reg;
    logic [FMT_W-1:0] tgt_fmt_reg;
    logic             src_be_reg;
    logic             tgt_be_reg;
    fmt_t             src_info;
    fmt_t             tgt_info;
    logic             fmt_err;

    logic             v1_reg, v2_reg, v3_reg;
    logic             load1, load2, load3;
    logic [BYTE_W-1:0] comp1_reg [COMP_N];
    logic [BYTE_W-1:0] comp1_next [COMP_N];
    logic [BYTE_W-1:0] comp2_reg [COMP_N];
    logic [BYTE_W-1:0] comp2_next [COMP_N];
    logic             last1_reg, last2_reg, last3_reg;
    logic             err1_reg, err2_reg, err3_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] pix_next;

    logic [BYTE_W-1:0]   src_byte [COMP_N];
    logic signed [5:0]   amt      [COMP_N];
    logic signed [5:0]   neg_amt  [COMP_N];
    logic [BYTE_W-1:0]   moved    [COMP_N];
    logic [BYTE_W-1:0]   tmask    [COMP_N];

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg <= '0;
            tgt_fmt_reg <= '0;
            src_be_reg  <= 1'b0;
            tgt_be_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SRC_FMT: src_fmt_reg <= cfg_wdata;
                REG_TGT_FMT: tgt_fmt_reg <= cfg_wdata;
                REG_SRC_BE:  src_be_reg  <= cfg_wdata[0];
                REG_TGT_BE:  tgt_be_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // format decode
    rgbpfc_decode u_src_decode (
        .fmt_word   (src_fmt_reg),
        .big_endian (src_be_reg),
        .info       (src_info)
    );

    rgbpfc_decode u_tgt_decode (
        .fmt_word   (tgt_fmt_reg),
        .big_endian (tgt_be_reg),
        .info       (tgt_info)
    );

    assign fmt_err = src_info.bad | tgt_info.bad;

    // stage load enables
    assign load3    = !v3_reg || m_tready;
    assign load2    = !v2_reg || load3;
    assign load1    = !v1_reg || load2;
    assign s_tready = load1;

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (load1) v1_reg <= s_tvalid;
            if (load2) v2_reg <= v1_reg;
            if (load3) v3_reg <= v2_reg;
        end
    end

    // stage 1: pick source byte, shift field down, keep its bits
    always_comb begin
        for (int c = 0; c < COMP_N; c++) begin
            src_byte[c]   = s_tdata[BYTE_W*src_info.pos[c] +: BYTE_W];
            comp1_next[c] = (src_byte[c] >> src_info.shift[c][2:0])
                          & (8'hFF >> src_info.loss[c]);
        end
    end

    // stage 2: move by loss difference plus target bit offset, mask to target field
    always_comb begin
        for (int c = 0; c < COMP_N; c++) begin
            amt[c] = $signed({2'b00, src_info.loss[c]}) - $signed({2'b00, tgt_info.loss[c]})
                   + $signed({3'b000, tgt_info.shift[c][2:0]});
            neg_amt[c] = -amt[c];
            if (!amt[c][5]) begin
                moved[c] = comp1_reg[c] << amt[c][3:0];
            end else begin
                moved[c] = comp1_reg[c] >> neg_amt[c][3:0];
            end
            tmask[c]      = (8'hFF >> tgt_info.loss[c]) << tgt_info.shift[c][2:0];
            comp2_next[c] = moved[c] & tmask[c];
        end
    end

    // stage 3: place each field in its target byte, or zero the pixel on a format error
    always_comb begin
        pix_next = '0;
        for (int b = 0; b < PIX_BYTES; b++) begin
            for (int c = 0; c < COMP_N; c++) begin
                if (tgt_info.pos[c] == POS_W'(b)) begin
                    pix_next[BYTE_W*b +: BYTE_W] = pix_next[BYTE_W*b +: BYTE_W]
                                                 | comp2_reg[c];
                end
            end
        end
        if (err2_reg) begin
            pix_next = '0;
        end
    end

    // stage data registers
    always_ff @(posedge aclk) begin
        if (load1) begin
            comp1_reg <= comp1_next;
            last1_reg <= s_tlast;
            err1_reg  <= fmt_err;
        end
        if (load2) begin
            comp2_reg <= comp2_next;
            last2_reg <= last1_reg;
            err2_reg  <= err1_reg;
        end
        if (load3) begin
            pix_reg   <= pix_next;
            last3_reg <= last2_reg;
            err3_reg  <= err2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = pix_reg;
    assign m_tlast  = last3_reg;
    assign m_tuser  = err3_reg;

`ifndef SYNTHESIS
    // an errored color never carries pixel bits
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("format error with nonzero pixel");

    // input backpressure only when every stage is full and the output is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg && v2_reg && v3_reg && !m_tready)
        else $error("input stalled with room in pipeline");

    // reset empties the pipeline
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !v1_reg && !v2_reg)
        else $error("pipeline not empty after reset");
`endif

endmodule

// ----- sv/rgbpfc_decode.sv -----
module rgbpfc_decode
    import rgbpfc_pkg::*;
(
    input  logic [FMT_W-1:0] fmt_word,
    input  logic             big_endian,
    output fmt_t             info
);

    logic [CNT_W-1:0]   byte_cnt;
    logic [LOSS_W-1:0]  raw_loss [COMP_N];
    logic [LOSS_W-1:0]  loss     [COMP_N];
    logic [SHIFT_W-1:0] shift    [COMP_N];
    logic [LOSS_W-1:0]  span     [COMP_N];
    logic [SHIFT_W:0]   top_bit  [COMP_N];
    logic [CNT_W-1:0]   byte_no  [COMP_N];

    // unpack fields; flag loss above eight or a field not in one pixel byte
    always_comb begin
        byte_cnt = CNT_W'(fmt_word[1:0]) + CNT_W'(1);
        if (byte_cnt > CNT_W'(PIX_BYTES)) begin
            byte_cnt = CNT_W'(PIX_BYTES);
        end
        info.bad = 1'b0;
        for (int c = 0; c < COMP_N; c++) begin
            raw_loss[c] = fmt_word[LOSS_LSB + LOSS_W*c +: LOSS_W];
            shift[c]    = fmt_word[SHIFT_LSB + SHIFT_W*c +: SHIFT_W];
            if (raw_loss[c] > LOSS_W'(NO_BITS)) begin
                loss[c]  = LOSS_W'(NO_BITS);
                info.bad = 1'b1;
            end else begin
                loss[c] = raw_loss[c];
            end
            span[c]    = (loss[c] < LOSS_W'(NO_BITS - 1)) ? LOSS_W'(NO_BITS - 1) - loss[c]
                                                           : '0;
            top_bit[c] = {1'b0, shift[c]} + (SHIFT_W+1)'(span[c]);
            byte_no[c] = CNT_W'(shift[c][SHIFT_W-1:3]);
            // field crosses a byte boundary
            if (CNT_W'(top_bit[c][SHIFT_W:3]) != byte_no[c]) begin
                info.bad = 1'b1;
            end
            // field lies beyond the pixel
            if (byte_no[c] >= byte_cnt) begin
                info.bad = 1'b1;
            end
            info.loss[c]  = loss[c];
            info.shift[c] = shift[c];
            info.pos[c]   = big_endian ? POS_W'(byte_cnt - CNT_W'(1) - byte_no[c])
                                       : POS_W'(byte_no[c]);
        end
    end

endmodule

// ----- verif/rgb_pixel_format_convert_checker.sv -----
`timescale 1ns / 100ps

module rgb_pixel_format_convert_checker
    import rgbpfc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FMT_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [PIX_W-1:0]     s_tdata,   // [31:0] source_pixel
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [PIX_W-1:0]     m_tdata,   // [31:0] target_pixel
    input  logic                 m_tlast,
    input  logic                 m_tuser,   // [0] format_error
    output int                   fail_count,
    output int                   pending_count
);

    // unpacked view of one format word
    typedef struct packed {
        logic                           bad;
        logic [2:0]                     nbytes;
        logic [COMP_N-1:0][LOSS_W-1:0]  loss;
        logic [COMP_N-1:0][SHIFT_W-1:0] shift;
    } pix_fmt_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             err;
    } color_result_t;

    color_result_t    expected_colors[$];
    logic [FMT_W-1:0] src_fmt_q;
    logic [FMT_W-1:0] tgt_fmt_q;
    logic             src_be_q;
    logic             tgt_be_q;

    // split a format word, flag fields that cross a byte or leave the pixel
    function automatic pix_fmt_t decode_fmt(input logic [FMT_W-1:0] word);
        pix_fmt_t f;
        int       l;
        int       s;
        int       span;
        int       c;
        f = '0;
        f.nbytes = word[1:0] + 3'd1;
        if (f.nbytes > PIX_BYTES) begin
            f.nbytes = 3'(PIX_BYTES);
        end
        for (c = 0; c < COMP_N; c++) begin
            l = int'(word[LOSS_LSB + LOSS_W * c +: LOSS_W]);
            s = int'(word[SHIFT_LSB + SHIFT_W * c +: SHIFT_W]);
            if (l > NO_BITS) begin
                l = NO_BITS;
                f.bad = 1'b1;
            end
            span = (l < BYTE_W - 1) ? (BYTE_W - 1 - l) : 0;
            if (s / BYTE_W != (s + span) / BYTE_W) begin
                f.bad = 1'b1;
            end
            if (s / BYTE_W >= int'(f.nbytes)) begin
                f.bad = 1'b1;
            end
            f.loss[c]  = LOSS_W'(l);
            f.shift[c] = SHIFT_W'(s);
        end
        return f;
    endfunction

    // convert one color under the current formats
    function automatic color_result_t convert_color(input logic [PIX_W-1:0] pix,
                                                    input logic last);
        pix_fmt_t      sf;
        pix_fmt_t      tf;
        color_result_t r;
        int            c;
        int            sl;
        int            tl;
        int            ss;
        int            ts;
        int            sp;
        int            tp;
        int            v;
        int            amt;
        int            moved;
        int            mask;
        sf = decode_fmt(src_fmt_q);
        tf = decode_fmt(tgt_fmt_q);
        r.pixel = '0;
        r.last  = last;
        r.err   = sf.bad | tf.bad;
        if (!r.err) begin
            for (c = 0; c < COMP_N; c++) begin
                sl = int'(sf.loss[c]);
                tl = int'(tf.loss[c]);
                ss = int'(sf.shift[c]);
                ts = int'(tf.shift[c]);
                sp = src_be_q ? int'(sf.nbytes) - 1 - ss / BYTE_W : ss / BYTE_W;
                tp = tgt_be_q ? int'(tf.nbytes) - 1 - ts / BYTE_W : ts / BYTE_W;
                v = (int'(pix[BYTE_W * sp +: BYTE_W]) >> (ss % BYTE_W))
                    & ((1 << (BYTE_W - sl)) - 1);
                // negative move means a right shift
                amt = sl - tl + ts % BYTE_W;
                moved = (amt >= 0) ? ((v << amt) & 8'hFF) : (v >> (-amt));
                mask = (((1 << (BYTE_W - tl)) - 1) << (ts % BYTE_W)) & 8'hFF;
                r.pixel = r.pixel | (PIX_W'(moved & mask) << (BYTE_W * tp));
            end
        end
        return r;
    endfunction

    // track config, predict on each input request, compare on each output request
    always @(posedge aclk) begin : monitor
        color_result_t want;
        if (!aresetn) begin
            src_fmt_q  = '0;
            tgt_fmt_q  = '0;
            src_be_q   = 1'b0;
            tgt_be_q   = 1'b0;
            fail_count = 0;
            expected_colors.delete();
            pending_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_colors.size() == 0) begin
                    $error("unexpected result: target_pixel %h last_out %b format_error %b",
                           m_tdata, m_tlast, m_tuser);
                    fail_count = fail_count + 1;
                end else begin
                    want = expected_colors.pop_front();
                    if (m_tdata !== want.pixel) begin
                        $error("target_pixel: expected %h, actual %h", want.pixel, m_tdata);
                        fail_count = fail_count + 1;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_out: expected %b, actual %b", want.last, m_tlast);
                        fail_count = fail_count + 1;
                    end
                    if (m_tuser !== want.err) begin
                        $error("format_error: expected %b, actual %b", want.err, m_tuser);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_colors.push_back(convert_color(s_tdata, s_tlast));
            end
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_SRC_FMT: src_fmt_q = cfg_wdata;
                    REG_TGT_FMT: tgt_fmt_q = cfg_wdata;
                    REG_SRC_BE:  src_be_q  = cfg_wdata[0];
                    REG_TGT_BE:  tgt_be_q  = cfg_wdata[0];
                    default: ;
                endcase
            end
            pending_count <= expected_colors.size();
        end
    end

endmodule

// ----- verif/rgb_pixel_format_convert_tb.sv -----
`timescale 1ns / 100ps

module rgb_pixel_format_convert_tb;
    import rgbpfc_pkg::*;

    localparam int STALL_MAX   = 15;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 16;
    localparam int ITEM_TARGET = 550;
    localparam int CALM_FROM   = 470;
    localparam int HOLD_PHASE  = 4;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [FMT_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata;   // [31:0] source_pixel
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PIX_W-1:0]     m_tdata;   // [31:0] target_pixel
    logic                 m_tlast;
    logic                 m_tuser;   // [0] format_error

    int fail_count;
    int pending_count;
    int sent;
    bit idle_on;
    bit hold_request;

    rgb_pixel_format_convert i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    rgb_pixel_format_convert_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, STALL_MAX)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // pack a format word: bytes minus one, losses r g b, shifts r g b
    function automatic logic [FMT_W-1:0] make_fmt(input int m1, input int lr, input int lg,
                                                  input int lb, input int sr, input int sg,
                                                  input int sb);
        logic [FMT_W-1:0] word;
        word = '0;
        word[1:0] = 2'(m1);
        word[LOSS_LSB +: LOSS_W]               = LOSS_W'(lr);
        word[LOSS_LSB + LOSS_W +: LOSS_W]      = LOSS_W'(lg);
        word[LOSS_LSB + 2 * LOSS_W +: LOSS_W]  = LOSS_W'(lb);
        word[SHIFT_LSB +: SHIFT_W]              = SHIFT_W'(sr);
        word[SHIFT_LSB + SHIFT_W +: SHIFT_W]    = SHIFT_W'(sg);
        word[SHIFT_LSB + 2 * SHIFT_W +: SHIFT_W] = SHIFT_W'(sb);
        return word;
    endfunction

    // mostly well-formed formats with random layout, some raw noise
    function automatic logic [FMT_W-1:0] rand_fmt();
        int nbytes;
        int span;
        int c;
        int l[3];
        int s[3];
        if ($urandom_range(0, 3) == 0) begin
            return FMT_W'($urandom);
        end
        nbytes = $urandom_range(1, PIX_BYTES);
        for (c = 0; c < COMP_N; c++) begin
            l[c] = $urandom_range(0, NO_BITS);
            span = (l[c] < BYTE_W - 1) ? (BYTE_W - 1 - l[c]) : 0;
            s[c] = $urandom_range(0, nbytes - 1) * BYTE_W + $urandom_range(0, BYTE_W - 1 - span);
        end
        return make_fmt(nbytes - 1, l[0], l[1], l[2], s[0], s[1], s[2]);
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [FMT_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // drop valid and wait until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic apply_formats(input logic [FMT_W-1:0] src, input logic [FMT_W-1:0] tgt,
                                 input logic src_be, input logic tgt_be);
        wait_drained();
        write_reg(REG_SRC_FMT, src);
        write_reg(REG_TGT_FMT, tgt);
        write_reg(REG_SRC_BE, FMT_W'(src_be));
        write_reg(REG_TGT_BE, FMT_W'(tgt_be));
    endtask

    // offer one color request, with an optional idle burst ahead of it
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, STALL_MAX)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    initial begin : stimulus
        int phase;
        int n;
        int pick;
        logic [PIX_W-1:0] pix;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_SRC_FMT;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        sent         = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset formats: one byte, all three fields on the full byte
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b1);

        // 3-byte little endian to 4-byte big endian, no loss
        apply_formats(make_fmt(2, 0, 0, 0, 16, 8, 0), make_fmt(3, 0, 0, 0, 24, 16, 8),
                      1'b0, 1'b1);
        send_pixel('0, 1'b0);
        send_pixel('1, 1'b0);
        send_pixel(32'h1234_5678, 1'b1);
        send_pixel(32'hA5C3_5A3C, 1'b0);

        // lossy target: moves of zero, right and left
        apply_formats(make_fmt(3, 0, 1, 4, 24, 9, 4), make_fmt(1, 3, 5, 0, 3, 8, 0),
                      1'b1, 1'b0);
        send_pixel('1, 1'b0);
        send_pixel($urandom, 1'b0);
        send_pixel($urandom, 1'b1);
        send_pixel(32'h8001_7FFE, 1'b0);

        // empty fields and top-bit extremes
        apply_formats(make_fmt(0, 6, 8, 7, 0, 7, 7), make_fmt(3, 0, 0, 8, 0, 8, 31),
                      1'b0, 1'b1);
        send_pixel('1, 1'b1);
        send_pixel(32'h0000_00C5, 1'b0);

        // loss above eight in source, all-ones word in target
        apply_formats(make_fmt(3, 9, 0, 0, 0, 8, 16), make_fmt(3, 0, 0, 0, 0, 8, 16),
                      1'b0, 1'b0);
        send_pixel('1, 1'b1);
        apply_formats(make_fmt(3, 0, 0, 0, 0, 8, 16), '1, 1'b0, 1'b0);
        send_pixel('1, 1'b0);

        // field crossing a byte
        apply_formats(make_fmt(1, 3, 2, 3, 8, 5, 0), make_fmt(1, 0, 0, 0, 8, 0, 0),
                      1'b1, 1'b1);
        send_pixel('1, 1'b0);

        // field outside the pixel, also one with no bits
        apply_formats(make_fmt(0, 0, 0, 0, 0, 0, 0), make_fmt(1, 0, 0, 0, 16, 0, 8),
                      1'b0, 1'b0);
        send_pixel('1, 1'b1);
        apply_formats(make_fmt(0, 0, 0, 8, 0, 0, 31), make_fmt(0, 0, 0, 0, 0, 0, 0),
                      1'b0, 1'b0);
        send_pixel('1, 1'b0);

        // zero words with big endian on both sides
        apply_formats('0, '0, 1'b1, 1'b1);
        send_pixel('1, 1'b1);

        // random phases, formats changed only while drained
        phase = 0;
        while (sent < ITEM_TARGET) begin
            phase++;
            apply_formats(rand_fmt(), rand_fmt(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            if (phase == HOLD_PHASE) begin
                hold_request = 1'b1;
            end
            if (sent >= CALM_FROM) begin
                idle_on = 1'b0;
            end
            n = $urandom_range(15, 50);
            repeat (n) begin
                pick = $urandom_range(0, 9);
                pix = (pick == 0) ? '1 : (pick == 1) ? '0 : PIX_W'($urandom);
                send_pixel(pix, ($urandom_range(0, 7) == 0));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
